>>> hdl/pfas_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfas_pkg
// Shared widths, operation codes and register indexes of the prime field
// add/subtract unit.
// ----------------------------------------------------------------------------
package pfas_pkg;

    localparam int WORD_W      = 64;
    localparam int WORD_COUNT  = 3;
    localparam int FIELD_W     = WORD_W * WORD_COUNT;
    localparam int OPND_TOP_W  = 55;
    localparam int PRIME_TOP_W = 54;
    localparam int REQ_TYPE_W  = 3;
    localparam int CFG_INDEX_W = 2;

    typedef logic [FIELD_W-1:0]    field_t;
    typedef logic [REQ_TYPE_W-1:0] op_t;

    localparam op_t OP_ADD     = 3'd0;
    localparam op_t OP_SUB     = 3'd1;
    localparam op_t OP_NEGATE  = 3'd2;
    localparam op_t OP_HALVE   = 3'd3;
    localparam op_t OP_CORRECT = 3'd4;

    localparam logic [CFG_INDEX_W-1:0] REG_PRIME_WORD0 = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PRIME_WORD1 = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PRIME_WORD2 = 2'd2;

endpackage
`default_nettype wire

>>> hdl/pfas_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfas channel interfaces
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pfas_req_if
    import pfas_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [REQ_TYPE_W-1:0] req_type;
    logic [WORD_W-1:0]     a_word0;
    logic [WORD_W-1:0]     a_word1;
    logic [OPND_TOP_W-1:0] a_word2;
    logic [WORD_W-1:0]     b_word0;
    logic [WORD_W-1:0]     b_word1;
    logic [OPND_TOP_W-1:0] b_word2;

    modport source (output valid, req_type, a_word0, a_word1, a_word2,
                    b_word0, b_word1, b_word2, input ready);
    modport sink   (input valid, req_type, a_word0, a_word1, a_word2,
                    b_word0, b_word1, b_word2, output ready);
endinterface

interface pfas_rsp_if
    import pfas_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] c_word0;
    logic [WORD_W-1:0] c_word1;
    logic [WORD_W-1:0] c_word2;

    modport source (output valid, c_word0, c_word1, c_word2, input ready);
    modport sink   (input valid, c_word0, c_word1, c_word2, output ready);
endinterface

interface pfas_cfg_if
    import pfas_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [WORD_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> hdl/pfas_addsub.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfas_addsub
// Full-width field adder: x + y, or x - y when sub is set, with carry out.
// ----------------------------------------------------------------------------
module pfas_addsub
    import pfas_pkg::*;
(
    input  wire field_t x,
    input  wire field_t y,
    input  wire logic   sub,
    output field_t      sum,
    output logic        carry
);

    logic [FIELD_W:0] total;

    assign total = {1'b0, x} + {1'b0, y ^ {FIELD_W{sub}}} + {{FIELD_W{1'b0}}, sub};
    assign sum   = total[FIELD_W-1:0];
    assign carry = total[FIELD_W];

endmodule
`default_nettype wire

>>> hdl/prime_field_add_sub_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prime_field_add_sub_unit
// 192-bit prime field add, subtract, negate, halve and correct.
// ----------------------------------------------------------------------------
// Each request word gives an operation and operands a and b and yields one
// response word c. The unit is a three-register pipeline: an input register,
// a middle register after the first 192-bit adder, and an output register
// after the second 192-bit adder and result select. It accepts one request
// per cycle while the response side does not stall; each request passes the
// middle and then the output register. One 192-bit adder in each stage sets
// the clock path. The user must write the prime through the configuration
// channel while the unit is idle; it is not enforced. 2p is a wired shift.
// ----------------------------------------------------------------------------
module prime_field_add_sub_unit
    import pfas_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    pfas_cfg_if.sink   cfg,
    pfas_req_if.sink   req,
    pfas_rsp_if.source rsp
);

    // configuration
    logic [WORD_W-1:0]      prime_word0_reg;
    logic [WORD_W-1:0]      prime_word1_reg;
    logic [PRIME_TOP_W-1:0] prime_word2_reg;
    field_t                 prime;
    field_t                 prime2;

    assign cfg.ready = 1'b1;
    assign prime  = {{(FIELD_W - 2*WORD_W - PRIME_TOP_W){1'b0}}, prime_word2_reg,
                     prime_word1_reg, prime_word0_reg};
    assign prime2 = {prime[FIELD_W-2:0], 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prime_word0_reg <= '0;
            prime_word1_reg <= '0;
            prime_word2_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_PRIME_WORD0: prime_word0_reg <= cfg.data;
                REG_PRIME_WORD1: prime_word1_reg <= cfg.data;
                REG_PRIME_WORD2: prime_word2_reg <= cfg.data[PRIME_TOP_W-1:0];
                default:         ;
            endcase
        end
    end

    // pipeline control
    logic in_valid_reg;
    logic mid_valid_reg;
    logic out_valid_reg;
    logic in_load;
    logic mid_load;
    logic out_load;

    assign out_load  = !out_valid_reg || rsp.ready;
    assign mid_load  = !mid_valid_reg || out_load;
    assign in_load   = !in_valid_reg || mid_load;
    assign req.ready = in_load;
    assign rsp.valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_load)
            begin
                in_valid_reg <= req.valid;
            end
            if (mid_load)
            begin
                mid_valid_reg <= in_valid_reg;
            end
            if (out_load)
            begin
                out_valid_reg <= mid_valid_reg;
            end
        end
    end

    // input register
    op_t    in_op_reg;
    field_t in_a_reg;
    field_t in_b_reg;

    always_ff @(posedge clk)
    begin
        if (in_load && req.valid)
        begin
            in_op_reg <= req.req_type;
            in_a_reg  <= {{(FIELD_W - 2*WORD_W - OPND_TOP_W){1'b0}}, req.a_word2,
                          req.a_word1, req.a_word0};
            in_b_reg  <= {{(FIELD_W - 2*WORD_W - OPND_TOP_W){1'b0}}, req.b_word2,
                          req.b_word1, req.b_word0};
        end
    end

    // first adder
    field_t s1_x;
    field_t s1_y;
    logic   s1_sub;
    field_t s1_sum;
    logic   s1_carry;

    always_comb
    begin
        s1_x   = '0;
        s1_y   = '0;
        s1_sub = 1'b0;
        unique case (in_op_reg)
            OP_ADD:
            begin
                s1_x = in_a_reg;
                s1_y = in_b_reg;
            end
            OP_SUB:
            begin
                s1_x   = in_a_reg;
                s1_y   = in_b_reg;
                s1_sub = 1'b1;
            end
            OP_NEGATE:
            begin
                s1_x   = prime2;
                s1_y   = in_a_reg;
                s1_sub = 1'b1;
            end
            OP_HALVE:
            begin
                s1_x = in_a_reg;
                s1_y = in_a_reg[0] ? prime : '0;
            end
            OP_CORRECT:
            begin
                s1_x = in_a_reg;
            end
            default:
            begin
                s1_x = '0;
            end
        endcase
    end

    pfas_addsub u_addsub_first (
        .x     (s1_x),
        .y     (s1_y),
        .sub   (s1_sub),
        .sum   (s1_sum),
        .carry (s1_carry)
    );

    // middle register
    op_t    mid_op_reg;
    field_t mid_x_reg;
    logic   mid_borrow_reg;

    always_ff @(posedge clk)
    begin
        if (mid_load && in_valid_reg)
        begin
            mid_op_reg     <= in_op_reg;
            mid_x_reg      <= s1_sum;
            mid_borrow_reg <= (in_op_reg == OP_SUB) && !s1_carry;
        end
    end

    // second adder and select
    logic   s2_twice;
    logic   s2_sub;
    field_t s2_sum;
    logic   s2_carry;
    field_t c_next;

    assign s2_twice = (mid_op_reg == OP_ADD) || (mid_op_reg == OP_SUB);
    assign s2_sub   = (mid_op_reg != OP_SUB);

    pfas_addsub u_addsub_second (
        .x     (mid_x_reg),
        .y     (s2_twice ? prime2 : prime),
        .sub   (s2_sub),
        .sum   (s2_sum),
        .carry (s2_carry)
    );

    always_comb
    begin
        unique case (mid_op_reg)
            OP_ADD:     c_next = s2_carry ? s2_sum : mid_x_reg;
            OP_SUB:     c_next = mid_borrow_reg ? s2_sum : mid_x_reg;
            OP_NEGATE:  c_next = mid_x_reg;
            OP_HALVE:   c_next = {1'b0, mid_x_reg[FIELD_W-1:1]};
            OP_CORRECT: c_next = s2_carry ? s2_sum : mid_x_reg;
            default:    c_next = '0;
        endcase
    end

    // output register
    field_t c_reg;

    always_ff @(posedge clk)
    begin
        if (out_load && mid_valid_reg)
        begin
            c_reg <= c_next;
        end
    end

    assign rsp.c_word0 = c_reg[WORD_W-1:0];
    assign rsp.c_word1 = c_reg[2*WORD_W-1:WORD_W];
    assign rsp.c_word2 = c_reg[3*WORD_W-1:2*WORD_W];

    // checks
    assert property (@(posedge clk) disable iff (!rst_n)
        (mid_valid_reg && out_load) |=> out_valid_reg)
        else $error("middle word lost on advance");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !mid_load) |=> (in_valid_reg && $stable(in_op_reg)))
        else $error("input stage changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.ready && !mid_valid_reg) |=> !rsp.valid)
        else $error("response word repeated");

    assert property (@(posedge clk) disable iff (!rst_n)
        (mid_valid_reg && (mid_op_reg != OP_SUB)) |-> !mid_borrow_reg)
        else $error("stale borrow on non-subtract word");

endmodule
`default_nettype wire
